// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/madt_pkg.sv
// ----------------------------------------------------------------------------
// madt_pkg
// types and constants of the alarm deadline table
// ----------------------------------------------------------------------------
package madt_pkg;

  localparam int MODE_W   = 2;
  localparam int NOW_W    = 32;
  localparam int DELAY_W  = 25;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 33;
  localparam int TOL_W    = 4;
  localparam int STATUS_W = 3;
  localparam int PCNT_W   = 4;

  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DELAY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RESET = 4'd1;
  localparam logic [ID_W-1:0]  ID_FIRST  = 16'd1;
  localparam logic [ID_W-1:0]  ID_LAST   = 16'hFFFF;
  localparam logic [ID_W-1:0]  ID_NONE   = 16'd0;

  typedef struct packed {
    logic [TIME_W-1:0] fire;
    logic [ID_W-1:0]   ident;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// File: hdl/madt_cell.sv
// ----------------------------------------------------------------------------
// madt_cell
// one queue cell: loads a new value or takes its right neighbor's value
// ----------------------------------------------------------------------------
module madt_cell import madt_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] right_data,
  output logic [W-1:0] q
);

  logic [W-1:0] data_r;

  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      data_r <= load_data;
    end else if (ctrl.shift) begin
      data_r <= right_data;
    end else begin
      data_r <= data_r;
    end
  end

  assign q = data_r;

endmodule

// File: hdl/multi_alarm_deadline_table.sv
// ----------------------------------------------------------------------------
// multi_alarm_deadline_table
// ordered table of one-shot alarms kept in a row of queue cells
//
//   channel | direction | ports
//   in      | in        | in_valid in_ready in_mode in_now_seconds ...
//   out     | out       | out_valid out_ready out_status ... out_next_delay
//   cfg     | in        | cfg_valid cfg_ready cfg_fire_tolerance
//
// set: FIN and EMIT states lie between accept and result; cancel and tick
// scan: one cell popped per cycle from the row head, kept entries pushed
// back at the tail; a tick then gives one result per cycle per fired alarm
// while out_ready holds. in_ready is high only while no item is at work; out
// register holds a result until taken. reset: empty table, next id 1.
// ----------------------------------------------------------------------------
module multi_alarm_deadline_table import madt_pkg::*; #(
  parameter int MAX_ALARMS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [NOW_W-1:0]    in_now_seconds,
  input  logic [DELAY_W-1:0]  in_delay_seconds,
  input  logic [ID_W-1:0]     in_target_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_alarm_id,
  output logic                out_last,
  output logic [PCNT_W-1:0]   out_pending_count,
  output logic                out_any_pending,
  output logic [TIME_W-1:0]   out_next_delay,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_W-1:0]    cfg_fire_tolerance
);

  localparam int CW = $clog2(MAX_ALARMS + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TOL_W-1:0]    tol_r;
  logic [CW-1:0]       left_r, left_nxt;
  logic [CW-1:0]       len_r, len_nxt;
  logic [CW-1:0]       fq_len_r, fq_len_nxt;
  logic                hit_r, hit_nxt;
  logic                have_min_r, have_min_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [NOW_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]   limit_r, limit_nxt;
  logic [ID_W-1:0]     target_r, target_nxt;
  logic [TIME_W-1:0]   min_acc_r, min_acc_nxt;
  logic [TIME_W-1:0]   tbl_min_r, tbl_min_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [TIME_W-1:0]   nd_r, nd_nxt;
  logic [STATUS_W-1:0] ostatus_r, ostatus_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic                olast_r, olast_nxt;
  logic [PCNT_W-1:0]   opcnt_r, opcnt_nxt;
  logic                oany_r, oany_nxt;
  logic [TIME_W-1:0]   ond_r, ond_nxt;
  logic                out_load;

  entry_t              tbl_q [MAX_ALARMS];
  logic [ID_W-1:0]     fq_q  [MAX_ALARMS];
  entry_t              head;
  entry_t              tbl_din;
  logic                tbl_shift, tbl_load;
  logic [CW-1:0]       tbl_widx;
  logic                fq_shift, fq_load;
  logic [CW-1:0]       fq_widx;
  logic [TIME_W-1:0]   set_fire;
  logic [TIME_W-1:0]   now_ext;
  logic                head_drop;
  logic [CW+PCNT_W-1:0] count_ext;

  // row of table cells and row of fired-id cells
  for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cells
    cell_ctrl_t      tctrl, fctrl;
    logic [EW-1:0]   t_right, t_q;
    logic [ID_W-1:0] f_right;

    assign tctrl.shift = tbl_shift;
    assign tctrl.load  = tbl_load && (tbl_widx == CW'(i));
    assign fctrl.shift = fq_shift;
    assign fctrl.load  = fq_load && (fq_widx == CW'(i));

    if (i == MAX_ALARMS - 1) begin : g_tail
      assign t_right = t_q;
      assign f_right = fq_q[i];
    end else begin : g_mid
      assign t_right = tbl_q[i+1];
      assign f_right = fq_q[i+1];
    end

    madt_cell #(.W(EW)) u_tcell (
      .clk        (clk),
      .ctrl       (tctrl),
      .load_data  (tbl_din),
      .right_data (t_right),
      .q          (t_q)
    );
    assign tbl_q[i] = t_q;

    madt_cell #(.W(ID_W)) u_fcell (
      .clk        (clk),
      .ctrl       (fctrl),
      .load_data  (head.ident),
      .right_data (f_right),
      .q          (fq_q[i])
    );
  end

  assign head      = tbl_q[0];
  assign set_fire  = {1'b0, in_now_seconds} + {{(TIME_W-DELAY_W){1'b0}}, in_delay_seconds};
  assign now_ext   = {1'b0, now_r};
  assign head_drop = (mode_r == MODE_TICK) ? (head.fire <= limit_r)
                                           : (head.ident == target_r);
  assign count_ext = {{PCNT_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    id_nxt         = id_r;
    left_nxt       = left_r;
    len_nxt        = len_r;
    fq_len_nxt     = fq_len_r;
    hit_nxt        = hit_r;
    have_min_nxt   = have_min_r;
    mode_nxt       = mode_r;
    now_nxt        = now_r;
    limit_nxt      = limit_r;
    target_nxt     = target_r;
    min_acc_nxt    = min_acc_r;
    tbl_min_nxt    = tbl_min_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    nd_nxt         = nd_r;
    tbl_shift      = 1'b0;
    tbl_load       = 1'b0;
    tbl_widx       = len_r - CW'(1);
    tbl_din        = head;
    fq_shift       = 1'b0;
    fq_load        = 1'b0;
    fq_widx        = fq_len_r;
    out_load       = 1'b0;
    ostatus_nxt    = res_status_r;
    oid_nxt        = res_id_r;
    olast_nxt      = 1'b1;
    opcnt_nxt      = count_ext[PCNT_W-1:0];
    oany_nxt       = (count_r != '0);
    ond_nxt        = nd_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          now_nxt    = in_now_seconds;
          target_nxt = in_target_id;
          limit_nxt  = {1'b0, in_now_seconds} + {{(TIME_W-TOL_W){1'b0}}, tol_r};
          unique case (in_mode)
            MODE_SET: begin
              state_nxt = S_FIN;
              priority if (in_delay_seconds == '0) begin
                res_status_nxt = ST_BAD_DELAY;
                res_id_nxt     = ID_NONE;
              end else if (count_r >= CW'(MAX_ALARMS)) begin
                res_status_nxt = ST_FULL;
                res_id_nxt     = ID_NONE;
              end else begin
                tbl_load       = 1'b1;
                tbl_widx       = count_r;
                tbl_din        = '{fire: set_fire, ident: id_r};
                count_nxt      = count_r + CW'(1);
                id_nxt         = (id_r == ID_LAST) ? ID_FIRST : id_r + ID_FIRST;
                tbl_min_nxt    = (count_r == '0 || set_fire < tbl_min_r) ? set_fire
                                                                         : tbl_min_r;
                res_status_nxt = ST_OK;
                res_id_nxt     = id_r;
              end
            end
            MODE_CANCEL, MODE_TICK: begin
              state_nxt    = S_SCAN;
              left_nxt     = count_r;
              len_nxt      = count_r;
              fq_len_nxt   = '0;
              hit_nxt      = 1'b0;
              have_min_nxt = 1'b0;
            end
            default: begin
              state_nxt      = S_FIN;
              res_status_nxt = ST_OK;
              res_id_nxt     = ID_NONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (left_r == '0) begin
          state_nxt   = S_FIN;
          count_nxt   = len_r;
          tbl_min_nxt = min_acc_r;
          if (mode_r == MODE_CANCEL) begin
            res_status_nxt = hit_r ? ST_OK : ST_NOT_FOUND;
            res_id_nxt     = hit_r ? target_r : ID_NONE;
          end else begin
            res_status_nxt = (fq_len_r == '0) ? ST_NONE_DUE : ST_OK;
            res_id_nxt     = ID_NONE;
          end
        end else begin
          tbl_shift = 1'b1;
          left_nxt  = left_r - CW'(1);
          if (head_drop) begin
            len_nxt = len_r - CW'(1);
            if (mode_r == MODE_TICK) begin
              fq_load    = 1'b1;
              fq_len_nxt = fq_len_r + CW'(1);
            end else begin
              hit_nxt = 1'b1;
            end
          end else begin
            tbl_load     = 1'b1;
            have_min_nxt = 1'b1;
            if (!have_min_r || head.fire < min_acc_r) begin
              min_acc_nxt = head.fire;
            end
          end
        end
      end
      S_FIN: begin
        state_nxt = S_EMIT;
        nd_nxt    = (count_r != '0 && tbl_min_r > now_ext) ? tbl_min_r - now_ext
                                                           : '0;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (mode_r == MODE_TICK && fq_len_r != '0) begin
            ostatus_nxt = ST_OK;
            oid_nxt     = fq_q[0];
            olast_nxt   = (fq_len_r == CW'(1));
            fq_shift    = 1'b1;
            fq_len_nxt  = fq_len_r - CW'(1);
            if (fq_len_r == CW'(1)) begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      id_r        <= ID_FIRST;
      tol_r       <= TOL_RESET;
      left_r      <= '0;
      len_r       <= '0;
      fq_len_r    <= '0;
      hit_r       <= 1'b0;
      have_min_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      id_r        <= id_nxt;
      left_r      <= left_nxt;
      len_r       <= len_nxt;
      fq_len_r    <= fq_len_nxt;
      hit_r       <= hit_nxt;
      have_min_r  <= have_min_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        tol_r <= cfg_fire_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    now_r        <= now_nxt;
    limit_r      <= limit_nxt;
    target_r     <= target_nxt;
    min_acc_r    <= min_acc_nxt;
    tbl_min_r    <= tbl_min_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    nd_r         <= nd_nxt;
    if (out_load) begin
      ostatus_r <= ostatus_nxt;
      oid_r     <= oid_nxt;
      olast_r   <= olast_nxt;
      opcnt_r   <= opcnt_nxt;
      oany_r    <= oany_nxt;
      ond_r     <= ond_nxt;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = ostatus_r;
  assign out_alarm_id      = oid_r;
  assign out_last          = olast_r;
  assign out_pending_count = opcnt_r;
  assign out_any_pending   = oany_r;
  assign out_next_delay    = ond_r;

endmodule

// File: hdl/madt_checker.sv
// ----------------------------------------------------------------------------
// madt_checker
// port-level checks on the result channel of the alarm table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module madt_checker import madt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ID_W-1:0]     out_alarm_id,
  input logic                out_last,
  input logic [PCNT_W-1:0]   out_pending_count,
  input logic                out_any_pending,
  input logic [TIME_W-1:0]   out_next_delay
);

  // stalled item holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_alarm_id) && $stable(out_status) && $stable(out_next_delay))

  // any_pending follows pending count
  `ASSERT_IMPLIES(a_any_cnt, clk, rst_n, out_valid, out_any_pending == (out_pending_count != '0))

  // empty table has no delay
  `ASSERT_IMPLIES(a_empty_nd, clk, rst_n, out_valid && !out_any_pending, out_next_delay == '0)

  // error results carry no id
  `ASSERT_IMPLIES(a_err_id, clk, rst_n, out_valid && out_status != ST_OK, out_alarm_id == ID_NONE)

  // only fired alarms come in groups
  `ASSERT_IMPLIES(a_multi_ok, clk, rst_n, out_valid && !out_last, out_status == ST_OK && out_alarm_id != ID_NONE)

endmodule

bind multi_alarm_deadline_table madt_checker u_madt_checker (.*);
